[rtl/mcof_pkg.sv]
package mcof_pkg;

   localparam int NUM_FIFOS_DEF  = 4;
   localparam int FIFO_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int INDEX_W        = 4;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_PUSH  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [INDEX_W-1:0] chan_id;
      logic [DATA_W-1:0]  write_data;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [1:0]        status;
      logic [DATA_W-1:0] lost_total;
   } rsp_word_type;

endpackage

[rtl/multi_channel_overwrite_fifo_top.sv]
// Bank of NUM_FIFOS ring FIFOs of 32-bit words, FIFO_DEPTH entries each,
// sharing one synchronous word memory.
// Request channel (req_valid/req_ready/req_word): each word names a FIFO and
// asks to clear it, pop its oldest word or push write_data. A push into a
// full FIFO overwrites the oldest word and bumps that FIFO's lost counter.
// Response channel (rsp_valid/rsp_ready/rsp_word): one word per request, in
// request order: popped data, status and the FIFO's lost count.
// Responses pass the read stage and then the output register, so rsp_valid
// rises only after both have been loaded for the accepted request.
// Throughput: one request per cycle unless the receiver stalls; pointers and
// counters live in flops, so the only memory access per request is one read
// (pop) or one write (push), and the read data is registered.
// When the receiver stalls, one request waits in the read stage and one in
// the output register; req_ready drops once both are occupied.
// Reset: all FIFOs empty, lost counters zero, no response pending. Memory
// contents are not cleared and are only read after being written.
module multi_channel_overwrite_fifo_top
   import mcof_pkg::*;
#(
   parameter int NUM_FIFOS  = NUM_FIFOS_DEF,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int F_W    = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int TOTAL  = NUM_FIFOS * FIFO_DEPTH;
   localparam int ADDR_W = $clog2(TOTAL);

   logic [DATA_W-1:0] mem [TOTAL];
   logic [DATA_W-1:0] rdata_ff;

   logic [PTR_W-1:0]  head_ff [NUM_FIFOS];
   logic [PTR_W-1:0]  tail_ff [NUM_FIFOS];
   logic [CNT_W-1:0]  fill_ff [NUM_FIFOS];
   logic [DATA_W-1:0] lost_ff [NUM_FIFOS];

   // read stage
   logic              s1_valid_ff;
   logic              s1_pop_ff;
   logic [1:0]        s1_status_ff;
   logic [DATA_W-1:0] s1_lost_ff;

   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   logic              out_free;
   logic              s1_move;
   logic              accept;
   logic              bad;
   logic [F_W-1:0]    fsel;
   logic [PTR_W-1:0]  head_cur;
   logic [PTR_W-1:0]  tail_cur;
   logic [CNT_W-1:0]  fill_cur;
   logic [DATA_W-1:0] lost_cur;
   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  tail_in;
   logic [CNT_W-1:0]  fill_in;
   logic [DATA_W-1:0] lost_in;
   logic [1:0]        status_in;
   logic              pop_ok;
   logic              push_en;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign bad      = {1'b0, req_word.chan_id} >= (INDEX_W + 1)'(NUM_FIFOS);
   assign fsel     = F_W'(req_word.chan_id);
   assign head_cur = head_ff[fsel];
   assign tail_cur = tail_ff[fsel];
   assign fill_cur = fill_ff[fsel];
   assign lost_cur = lost_ff[fsel];

   assign base_addr = ADDR_W'(FIFO_DEPTH) * ADDR_W'(fsel);
   assign rd_addr   = base_addr + ADDR_W'(head_cur);
   assign wr_addr   = base_addr + ADDR_W'(tail_cur);

   always_comb begin
      head_in   = head_cur;
      tail_in   = tail_cur;
      fill_in   = fill_cur;
      lost_in   = lost_cur;
      status_in = ST_OK;
      pop_ok    = 1'b0;
      push_en   = 1'b0;
      if (bad) begin
         status_in = ST_BAD_INDEX;
      end else begin
         unique case (req_word.req_type)
            REQ_CLEAR: begin
               head_in = '0;
               tail_in = '0;
               fill_in = '0;
               lost_in = '0;
            end
            REQ_POP: begin
               if (fill_cur == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  pop_ok  = 1'b1;
                  head_in = ring_next(head_cur);
                  fill_in = fill_cur - CNT_W'(1);
               end
            end
            REQ_PUSH: begin
               push_en = 1'b1;
               tail_in = ring_next(tail_cur);
               if (fill_cur >= CNT_W'(FIFO_DEPTH)) begin
                  head_in   = ring_next(head_cur);
                  lost_in   = lost_cur + DATA_W'(1);
                  status_in = ST_OVERFLOW;
               end else begin
                  fill_in = fill_cur + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !bad && push_en) begin
         mem[wr_addr] <= req_word.write_data;
      end
      if (accept && !bad && pop_ok) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FIFOS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
            lost_ff[i] <= '0;
         end
      end else if (accept && !bad) begin
         head_ff[fsel] <= head_in;
         tail_ff[fsel] <= tail_in;
         fill_ff[fsel] <= fill_in;
         lost_ff[fsel] <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pop_ff    <= pop_ok;
         s1_status_ff <= status_in;
         s1_lost_ff   <= bad ? '0 : lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_word_ff.read_data  <= s1_pop_ff ? rdata_ff : '0;
         rsp_word_ff.status     <= s1_status_ff;
         rsp_word_ff.lost_total <= s1_lost_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[verif/tb_top.sv]
module tb_top
   import mcof_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIFOS      = NUM_FIFOS_DEF;
   localparam int DEPTH      = FIFO_DEPTH_DEF;
   localparam int IDLE_LIMIT = 1000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   multi_channel_overwrite_fifo_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow of the fifo bank
   logic [DATA_W-1:0] word_mem [FIFOS][DEPTH];
   int unsigned       head_ptr [FIFOS];
   int unsigned       tail_ptr [FIFOS];
   int unsigned       fill_cnt [FIFOS];
   logic [31:0]       lost_cnt [FIFOS];

   rsp_word_type expected_rsp_q [$];
   int error_count  = 0;
   int n_requests   = 0;
   int n_pushes     = 0;
   int n_pops       = 0;
   int n_overwrites = 0;
   int n_empty_pops = 0;
   int n_bad_index  = 0;
   int n_responses  = 0;
   bit idle_req_on  = 1'b1;
   bit idle_rsp_on  = 1'b1;

   function automatic rsp_word_type fifo_bank_response(req_word_type w);
      rsp_word_type r;
      int f;
      r = '0;
      n_requests++;
      if (w.chan_id >= FIFOS) begin
         r.status = ST_BAD_INDEX;
         n_bad_index++;
         return r;
      end
      f = w.chan_id;
      case (w.req_type)
         REQ_CLEAR: begin
            head_ptr[f] = 0;
            tail_ptr[f] = 0;
            fill_cnt[f] = 0;
            lost_cnt[f] = '0;
         end
         REQ_POP: begin
            n_pops++;
            if (fill_cnt[f] == 0) begin
               r.status = ST_EMPTY;
               n_empty_pops++;
            end else begin
               r.read_data = word_mem[f][head_ptr[f]];
               head_ptr[f] = (head_ptr[f] + 1) % DEPTH;
               fill_cnt[f]--;
            end
         end
         REQ_PUSH: begin
            n_pushes++;
            word_mem[f][tail_ptr[f]] = w.write_data;
            tail_ptr[f] = (tail_ptr[f] + 1) % DEPTH;
            if (fill_cnt[f] >= DEPTH) begin
               // full: oldest word is dropped
               head_ptr[f] = (head_ptr[f] + 1) % DEPTH;
               lost_cnt[f] = lost_cnt[f] + 1;
               r.status = ST_OVERFLOW;
               n_overwrites++;
            end else begin
               fill_cnt[f]++;
            end
         end
         default: ;
      endcase
      r.lost_total = lost_cnt[f];
      return r;
   endfunction

   function automatic req_word_type make_word(logic [1:0] kind, logic [INDEX_W-1:0] idx,
                                              logic [DATA_W-1:0] data);
      req_word_type w;
      w.req_type   = kind;
      w.chan_id    = idx;
      w.write_data = data;
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      gap = idle_req_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(fifo_bank_response(w));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_bad_index();
      send_word(make_word(REQ_POP, 4'd0, 32'h1234_5678));
      send_word(make_word(REQ_POP, 4'(FIFOS - 1), 32'h0));
      send_word(make_word(REQ_PUSH, 4'(FIFOS), 32'hFFFF_FFFF));
      send_word(make_word(REQ_POP, 4'd15, 32'h0));
      send_word(make_word(REQ_CLEAR, 4'd9, 32'h0));
      send_word(make_word(REQ_UNUSED, 4'd1, 32'hDEAD_BEEF));
      wait_for_drain();
   endtask

   task automatic test_overwrite_oldest();
      logic [INDEX_W-1:0] f;
      f = 4'(FIFOS - 1);
      send_word(make_word(REQ_PUSH, f, 32'h0000_0000));
      send_word(make_word(REQ_PUSH, f, 32'hFFFF_FFFF));
      for (int i = 2; i <= DEPTH; i++)
         send_word(make_word(REQ_PUSH, f, $urandom()));
      send_word(make_word(REQ_POP, f, 32'h0));
      send_word(make_word(REQ_UNUSED, f, 32'h0));
      send_word(make_word(REQ_CLEAR, f, 32'h0));
      send_word(make_word(REQ_POP, f, 32'h0));
      wait_for_drain();
   endtask

   task automatic test_random_traffic(int total);
      req_word_type w;
      int push_pct;
      int roll;
      int mode;
      for (int n = 0; n < total; n++) begin
         if (n % 64 == 0) begin
            // cycle through every combination of sender and receiver idling
            mode        = (n / 64) % 4;
            idle_req_on = mode[0];
            idle_rsp_on = mode[1];
            push_pct    = $urandom_range(20, 85);
         end
         roll = $urandom_range(0, 99);
         if (roll < 2)
            w.req_type = REQ_CLEAR;
         else if (roll < 4)
            w.req_type = REQ_UNUSED;
         else if ($urandom_range(0, 99) < push_pct)
            w.req_type = REQ_PUSH;
         else
            w.req_type = REQ_POP;
         if ($urandom_range(0, 9) == 0)
            w.chan_id = 4'($urandom_range(FIFOS, 15));
         else
            w.chan_id = 4'($urandom_range(0, FIFOS - 1));
         w.write_data = $urandom();
         send_word(w);
      end
      wait_for_drain();
   endtask

   // response side: random stalls, compare against the oldest prediction
   initial begin : rsp_side
      int stall;
      rsp_word_type want;
      wait (reset == 1'b0);
      forever begin
         stall = idle_rsp_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n_responses++;
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word %h", $time, rsp_word);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_word.read_data !== want.read_data) begin
               error_count++;
               $display("%0t: read_data expected %h got %h", $time, want.read_data,
                        rsp_word.read_data);
            end
            if (rsp_word.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_word.status);
            end
            if (rsp_word.lost_total !== want.lost_total) begin
               error_count++;
               $display("%0t: lost_total expected %0d got %0d", $time, want.lost_total,
                        rsp_word.lost_total);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, %0d words still expected", $time, expected_rsp_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      for (int f = 0; f < FIFOS; f++) begin
         head_ptr[f] = 0;
         tail_ptr[f] = 0;
         fill_cnt[f] = 0;
         lost_cnt[f] = '0;
         for (int d = 0; d < DEPTH; d++) word_mem[f][d] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_bad_index();
      test_overwrite_oldest();
      test_random_traffic(1024);

      repeat (8) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected words never arrived", $time, expected_rsp_q.size());
      end
      $display("run: %0d requests, %0d responses; %0d pushes with %0d overwrites",
               n_requests, n_responses, n_pushes, n_overwrites);
      $display("run: %0d pops with %0d on empty fifos, %0d bad indexes",
               n_pops, n_empty_pops, n_bad_index);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
